// File: hw/rtl/jse_pkg.sv
// Shared constants for the Jaccard similarity engine.
`timescale 1ns / 1ps
`default_nettype none
package jse_pkg;
  localparam int ITEMS_DEFAULT     = 256;
  localparam int MAX_USERS_DEFAULT = 64;
  localparam int FRAC_BITS_DEFAULT = 16;

  localparam int CMD_W    = 2;
  localparam int ITEM_W   = 8;
  localparam int USER_W   = 32;
  localparam int SIM_W    = 17;
  localparam int SHARED_W = 7;
  localparam int UNION_W  = 8;
  localparam int STATUS_W = 2;
  localparam int SPAN_W   = 9;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
endpackage
`default_nettype wire

// File: hw/rtl/jse_ram.sv
// Generic synchronous RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module jse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule
`default_nettype wire

// File: hw/rtl/jaccard_similarity_engine.sv
// Top level of the Jaccard similarity engine over sorted per-item user lists.
//
//  Channel | Direction | tdata (low bit up)                         | tuser
//  s_*     | in        | first_item, second_item, user_id           | command
//  m_*     | out       | similarity, shared_count, union_count      | status
//
// A load reads the list length, then walks down from the tail, moving each larger entry
// up a slot until the new entry can be written in its sorted place.
// A query reads both lengths, runs the merge (at most la+lb-1 merge steps), then the
// shift-subtract divider; the single user-list memory sets the merge pace.
// A clear, and reset, sweep the length memory one entry per cycle.
// Reset is synchronous; the block takes no item until the reset sweep ends.
// One item is in work at a time; a new item is taken while a result waits at m_*.
`timescale 1ns / 1ps
`default_nettype none
module jaccard_similarity_engine #(
  parameter int ITEMS     = jse_pkg::ITEMS_DEFAULT,
  parameter int MAX_USERS = jse_pkg::MAX_USERS_DEFAULT,
  parameter int FRAC_BITS = jse_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // first_item[7:0], second_item[15:8], user_id[47:16]
  input  wire logic [jse_pkg::IN_DATA_W-1:0]   s_tdata,
  // command[1:0]
  input  wire logic [jse_pkg::CMD_W-1:0]       s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // similarity[16:0], shared_count[23:17], union_count[31:24]
  output logic      [jse_pkg::OUT_DATA_W-1:0]  m_tdata,
  // status[1:0]
  output logic      [jse_pkg::STATUS_W-1:0]    m_tuser
);
  import jse_pkg::*;

  localparam int IW   = $clog2(ITEMS);
  localparam int LW   = $clog2(MAX_USERS + 1);
  localparam int AW   = $clog2(ITEMS * MAX_USERS);
  localparam int UW   = LW + 1;
  localparam int SIMW = FRAC_BITS + 1;
  localparam int DCW  = $clog2(FRAC_BITS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SWEEP = 4'd1;
  localparam logic [3:0] S_QLEN  = 4'd2;
  localparam logic [3:0] S_MERGE = 4'd3;
  localparam logic [3:0] S_PREP  = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_LLEN  = 4'd6;
  localparam logic [3:0] S_LRD   = 4'd7;
  localparam logic [3:0] S_LCMP  = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  localparam logic [SIMW-1:0] SIM_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [3:0]           state;
  logic                 reply;
  logic [IW-1:0]        sweep_cnt;
  logic [SPAN_W-1:0]    span;
  logic [ITEM_W-1:0]    item_a;
  logic [IW-1:0]        idx_a;
  logic [AW-1:0]        base_a;
  logic [AW-1:0]        base_b;
  logic [USER_W-1:0]    uid;
  logic                 eq_q;
  logic                 oos_q;
  logic [LW-1:0]        la;
  logic [LW-1:0]        lb;
  logic [LW-1:0]        i;
  logic [LW-1:0]        j;
  logic [LW-1:0]        s;
  logic [LW-1:0]        k;
  logic [UW-1:0]        u;
  logic [UW-1:0]        rem;
  logic [FRAC_BITS-1:0] quo;
  logic [DCW-1:0]       dcnt;
  logic [SIMW-1:0]      res_sim;
  logic [LW-1:0]        res_shared;
  logic [UW-1:0]        res_union;
  logic [STATUS_W-1:0]  res_status;

  logic [ITEM_W-1:0]    in_first;
  logic [ITEM_W-1:0]    in_second;
  logic [IW+ITEM_W-1:0] wide_first;
  logic [IW+ITEM_W-1:0] wide_second;
  logic [IW-1:0]        in_idx_a;
  logic [IW-1:0]        in_idx_b;
  logic                 accept;

  logic                 len_we;
  logic [IW-1:0]        len_waddr;
  logic [LW-1:0]        len_wdata;
  logic [LW-1:0]        len_rdata_a;
  logic [LW-1:0]        len_rdata_b;
  logic                 usr_we;
  logic [AW-1:0]        usr_waddr;
  logic [USER_W-1:0]    usr_wdata;
  logic [AW-1:0]        usr_raddr_a;
  logic [AW-1:0]        usr_raddr_b;
  logic [USER_W-1:0]    usr_rdata_a;
  logic [USER_W-1:0]    usr_rdata_b;

  logic [LW-1:0]        i_n;
  logic [LW-1:0]        j_n;
  logic [LW-1:0]        s_n;
  logic [LW-1:0]        rd_i;
  logic [LW-1:0]        rd_j;
  logic                 gt;
  logic                 load_done;
  logic [UW:0]          r2;
  logic [UW-1:0]        tot;
  logic [SIMW+SIM_W-1:0]     sim_wide;
  logic [LW+SHARED_W-1:0]    shared_wide;
  logic [UW+UNION_W-1:0]     union_wide;

  assign in_first    = s_tdata[7:0];
  assign in_second   = s_tdata[15:8];
  assign wide_first  = {{IW{1'b0}}, in_first};
  assign wide_second = {{IW{1'b0}}, in_second};
  assign in_idx_a    = wide_first[IW-1:0];
  assign in_idx_b    = wide_second[IW-1:0];
  assign s_tready    = (state == S_IDLE);
  assign accept      = s_tvalid && s_tready;

  assign i_n = i + LW'(usr_rdata_a <= usr_rdata_b);
  assign j_n = j + LW'(usr_rdata_a >= usr_rdata_b);
  assign s_n = s + LW'(usr_rdata_a == usr_rdata_b);
  assign gt  = usr_rdata_a > uid;
  assign r2  = {rem, 1'b0};
  assign tot = UW'(la) + UW'(lb);

  assign load_done = ((state == S_LRD) && (k == '0)) || ((state == S_LCMP) && !gt);

  always_comb begin
    rd_i = '0;
    rd_j = '0;
    case (state)
      S_MERGE: begin
        rd_i = i_n;
        rd_j = j_n;
      end
      S_LRD: begin
        rd_i = k - LW'(1);
      end
      default: begin
        rd_i = '0;
        rd_j = '0;
      end
    endcase
  end

  assign usr_raddr_a = base_a + AW'(rd_i);
  assign usr_raddr_b = base_b + AW'(rd_j);
  assign usr_we      = ((state == S_LRD) && (k == '0)) || (state == S_LCMP);
  assign usr_waddr   = base_a + AW'(k);
  assign usr_wdata   = ((state == S_LCMP) && gt) ? usr_rdata_a : uid;

  assign len_we    = (state == S_SWEEP) || load_done;
  assign len_waddr = (state == S_SWEEP) ? sweep_cnt : idx_a;
  assign len_wdata = (state == S_SWEEP) ? '0 : la + LW'(1);

  jse_ram #(
    .WIDTH(USER_W),
    .DEPTH(ITEMS * MAX_USERS)
  ) u_users (
    .clk     (clk),
    .we      (usr_we),
    .waddr   (usr_waddr),
    .wdata   (usr_wdata),
    .raddr_a (usr_raddr_a),
    .rdata_a (usr_rdata_a),
    .raddr_b (usr_raddr_b),
    .rdata_b (usr_rdata_b)
  );

  jse_ram #(
    .WIDTH(LW),
    .DEPTH(ITEMS)
  ) u_lengths (
    .clk     (clk),
    .we      (len_we),
    .waddr   (len_waddr),
    .wdata   (len_wdata),
    .raddr_a (in_idx_a),
    .rdata_a (len_rdata_a),
    .raddr_b (in_idx_b),
    .rdata_b (len_rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      reply     <= 1'b0;
      sweep_cnt <= '0;
      span      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            item_a     <= in_first;
            idx_a      <= in_idx_a;
            base_a     <= AW'(in_idx_a) * AW'(MAX_USERS);
            base_b     <= AW'(in_idx_b) * AW'(MAX_USERS);
            uid        <= s_tdata[47:16];
            eq_q       <= (in_first == in_second);
            oos_q      <= ({1'b0, in_first} >= span) || ({1'b0, in_second} >= span);
            res_sim    <= '0;
            res_shared <= '0;
            res_union  <= '0;
            res_status <= ST_OK;
            case (s_tuser)
              CMD_LOAD: begin
                if (32'(in_first) >= 32'(ITEMS)) begin
                  res_status <= ST_RANGE;
                  state      <= S_FIN;
                end else begin
                  state <= S_LLEN;
                end
              end
              CMD_QUERY: begin
                state <= S_QLEN;
              end
              CMD_CLEAR: begin
                span      <= '0;
                sweep_cnt <= '0;
                reply     <= 1'b1;
                state     <= S_SWEEP;
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end
        S_SWEEP: begin
          sweep_cnt <= sweep_cnt + IW'(1);
          if (sweep_cnt == IW'(ITEMS - 1)) begin
            state <= reply ? S_FIN : S_IDLE;
          end
        end
        S_QLEN: begin
          la <= len_rdata_a;
          lb <= len_rdata_b;
          i  <= '0;
          j  <= '0;
          s  <= '0;
          if (eq_q) begin
            res_sim <= SIM_ONE;
            state   <= S_FIN;
          end else if (oos_q) begin
            state <= S_FIN;
          end else if ((len_rdata_a == '0) || (len_rdata_b == '0)) begin
            state <= S_PREP;
          end else begin
            state <= S_MERGE;
          end
        end
        S_MERGE: begin
          i <= i_n;
          j <= j_n;
          s <= s_n;
          if (!((i_n < la) && (j_n < lb))) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          u    <= tot - UW'(s);
          rem  <= UW'(s);
          quo  <= '0;
          dcnt <= '0;
          if (tot == '0) begin
            state <= S_FIN;
          end else begin
            res_shared <= s;
            res_union  <= tot - UW'(s);
            if (tot == UW'({s, 1'b0})) begin
              res_sim <= SIM_ONE;
              state   <= S_FIN;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (r2 >= {1'b0, u}) begin
            rem <= UW'(r2 - {1'b0, u});
          end else begin
            rem <= UW'(r2);
          end
          quo  <= {quo[FRAC_BITS-2:0], (r2 >= {1'b0, u})};
          dcnt <= dcnt + DCW'(1);
          if (dcnt == DCW'(FRAC_BITS - 1)) begin
            res_sim <= {1'b0, quo[FRAC_BITS-2:0], (r2 >= {1'b0, u})};
            state   <= S_FIN;
          end
        end
        S_LLEN: begin
          la <= len_rdata_a;
          k  <= len_rdata_a;
          if (len_rdata_a >= LW'(MAX_USERS)) begin
            res_status <= ST_FULL;
            state      <= S_FIN;
          end else begin
            state <= S_LRD;
          end
        end
        S_LRD: begin
          if (k == '0) begin
            if ((SPAN_W'(item_a) + SPAN_W'(1)) > span) begin
              span <= SPAN_W'(item_a) + SPAN_W'(1);
            end
            state <= S_FIN;
          end else begin
            state <= S_LCMP;
          end
        end
        S_LCMP: begin
          if (gt) begin
            k     <= k - LW'(1);
            state <= S_LRD;
          end else begin
            if ((SPAN_W'(item_a) + SPAN_W'(1)) > span) begin
              span <= SPAN_W'(item_a) + SPAN_W'(1);
            end
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            reply <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign sim_wide    = {{SIM_W{1'b0}}, res_sim};
  assign shared_wide = {{SHARED_W{1'b0}}, res_shared};
  assign union_wide  = {{UNION_W{1'b0}}, res_union};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_FIN) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {union_wide[UNION_W-1:0], shared_wide[SHARED_W-1:0],
                   sim_wide[SIM_W-1:0]};
      m_tuser  <= res_status;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// File: verif/tb.sv
// Testbench for the Jaccard similarity engine: random and directed items, scoreboard check.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import jse_pkg::*;

  localparam int NUM_ITEMS = 256;
  localparam int NUM_USERS = 64;
  localparam int FRAC = 16;
  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [ITEM_W-1:0] first_item;
    logic [ITEM_W-1:0] second_item;
    logic [USER_W-1:0] user_id;
  } request_t;

  typedef struct packed {
    logic [SIM_W-1:0] similarity;
    logic [SHARED_W-1:0] shared_count;
    logic [UNION_W-1:0] union_count;
    logic [STATUS_W-1:0] status;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [CMD_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0] m_tuser;

  jaccard_similarity_engine i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  request_t pending_items[$];
  answer_t expected_answers[$];
  logic [USER_W-1:0] user_table[NUM_ITEMS][NUM_USERS];
  int unsigned list_len[NUM_ITEMS];
  int unsigned span;
  int errors = 0;
  int cycles = 0;
  int hold_cycles = 0;
  bit hold_request = 1'b0;
  bit hold_started = 1'b0;
  int send_wait = 0;
  int recv_wait = 0;
  bit stimulus_done = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic answer_t predict_similarity(request_t r);
    answer_t a;
    int unsigned pos, i, j, s, tot, la, lb, x, y;
    a = '0;
    if (r.command == CMD_LOAD) begin
      x = r.first_item;
      if (x >= NUM_ITEMS) begin
        a.status = ST_RANGE;
      end else if (list_len[x] >= NUM_USERS) begin
        a.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < list_len[x] && user_table[x][pos] <= r.user_id) pos++;
        for (i = list_len[x]; i > pos; i--) user_table[x][i] = user_table[x][i-1];
        user_table[x][pos] = r.user_id;
        list_len[x]++;
        if (x + 1 > span) span = x + 1;
      end
    end else if (r.command == CMD_QUERY) begin
      x = r.first_item;
      y = r.second_item;
      if (x == y) begin
        a.similarity = SIM_W'(1 << FRAC);
      end else if (x < span && y < span) begin
        la = list_len[x];
        lb = list_len[y];
        i = 0; j = 0; s = 0;
        while (i < la && j < lb) begin
          if (user_table[x][i] == user_table[y][j]) begin
            s++; i++; j++;
          end else if (user_table[x][i] < user_table[y][j]) begin
            i++;
          end else begin
            j++;
          end
        end
        tot = la + lb;
        if (tot != 0) begin
          a.shared_count = SHARED_W'(s);
          a.union_count = UNION_W'(tot - s);
          a.similarity = SIM_W'((longint'(s) << FRAC) / (tot - s));
        end
      end
    end else if (r.command == CMD_CLEAR) begin
      foreach (list_len[k]) list_len[k] = 0;
      span = 0;
    end
    return a;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic push_item(logic [CMD_W-1:0] c, int f, int s, logic [USER_W-1:0] u);
    request_t r;
    r.command = c;
    r.first_item = ITEM_W'(f);
    r.second_item = ITEM_W'(s);
    r.user_id = u;
    pending_items.insert(pending_items.size(), r);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      expected_answers.insert(expected_answers.size(),
                              predict_similarity({s_tuser, s_tdata[7:0], s_tdata[15:8],
                                                  s_tdata[47:16]}));
      if (pending_items.size() > 0 && $urandom_range(0, 3) == 0) begin
        send_wait <= $urandom_range(0, 18);
        s_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        s_tdata <= {pending_items[0].user_id, pending_items[0].second_item,
                    pending_items[0].first_item};
        s_tuser <= pending_items[0].command;
        void'(pending_items.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end else if (!s_tvalid) begin
      if (send_wait > 0) begin
        send_wait <= send_wait - 1;
      end else if (pending_items.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= {pending_items[0].user_id, pending_items[0].second_item,
                    pending_items[0].first_item};
        s_tuser <= pending_items[0].command;
        void'(pending_items.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_cycles <= 0;
    end else if (hold_request && !hold_started) begin
      hold_cycles <= 3000;
      hold_started <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_answers.size() == 0) begin
          report_mismatch("unexpected item", 1, 0);
        end else begin
          if (m_tdata[16:0] != expected_answers[0].similarity)
            report_mismatch("similarity", m_tdata[16:0], expected_answers[0].similarity);
          if (m_tdata[23:17] != expected_answers[0].shared_count)
            report_mismatch("shared_count", m_tdata[23:17], expected_answers[0].shared_count);
          if (m_tdata[31:24] != expected_answers[0].union_count)
            report_mismatch("union_count", m_tdata[31:24], expected_answers[0].union_count);
          if (m_tuser != expected_answers[0].status)
            report_mismatch("status", m_tuser, expected_answers[0].status);
          void'(expected_answers.pop_front());
        end
      end
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        recv_wait <= $urandom_range(0, 18);
        m_tready <= ($urandom_range(0, 3) != 0);
      end else if (recv_wait > 0) begin
        recv_wait <= recv_wait - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int n, it, hot;
    span = 0;
    foreach (list_len[k]) list_len[k] = 0;
    for (n = 0; n < 10; n++) @(posedge clk);
    rst <= 1'b0;
    push_item(CMD_QUERY, 0, 1, 0);
    push_item(CMD_QUERY, 5, 5, 0);
    push_item(CMD_LOAD, 0, 0, 32'h0000_0000);
    push_item(CMD_LOAD, 0, 255, 32'hFFFF_FFFF);
    push_item(CMD_LOAD, 255, 0, 32'hFFFF_FFFF);
    push_item(CMD_LOAD, 255, 0, 32'h0000_0000);
    push_item(CMD_LOAD, 255, 0, 32'h0000_0000);
    push_item(CMD_QUERY, 0, 255, 0);
    push_item(CMD_QUERY, 255, 0, 0);
    push_item(CMD_QUERY, 3, 7, 0);
    push_item(CMD_UNUSED, 1, 2, 32'h1234_5678);
    for (n = 0; n < 64; n++) push_item(CMD_LOAD, 1, 0, USER_W'(n % 5));
    push_item(CMD_LOAD, 1, 0, 32'hAAAA_5555);
    push_item(CMD_LOAD, 2, 0, 32'h0000_0002);
    push_item(CMD_QUERY, 1, 2, 0);
    push_item(CMD_QUERY, 1, 255, 0);
    push_item(CMD_CLEAR, 0, 0, 0);
    push_item(CMD_QUERY, 0, 255, 0);
    for (n = 0; n < 1000; n++) begin
      if (n == 300) begin
        while (pending_items.size() > 40) @(posedge clk);
        hold_request = 1'b1;
      end
      it = $urandom_range(0, 99);
      hot = $urandom_range(0, 7);
      if (it < 55) begin
        push_item(CMD_LOAD, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : hot,
                  $urandom_range(0, 255),
                  ($urandom_range(0, 1) != 0) ? $urandom_range(0, 15) : $urandom());
      end else if (it < 92) begin
        push_item(CMD_QUERY, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : hot,
                  ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7),
                  $urandom());
      end else if (it < 96) begin
        push_item(CMD_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255), $urandom());
      end else begin
        push_item(CMD_UNUSED, $urandom_range(0, 255), $urandom_range(0, 255), $urandom());
      end
    end
    while (pending_items.size() > 0 || s_tvalid || expected_answers.size() > 0)
      @(posedge clk);
    for (n = 0; n < 400; n++) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
